// File: hw/rtl/sfd_pkg.sv
package sfd_pkg;

	// frame kinds carried at position two
	localparam logic [7:0] KIND_T = 8'h54;
	localparam logic [7:0] KIND_D = 8'h44;

	// default size limit of one frame in bytes
	localparam int FRAME_LIMIT_DEF = 256;

	// configuration register indexes
	localparam int CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_BYTE  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_BYTE = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_END_BYTE   = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_EXP_VER    = 8'd3;

	// reset value of the expected version register
	localparam logic [7:0] EXP_VER_RST = 8'd1;

	typedef struct packed {
		logic [7:0] sync_byte;
		logic [7:0] magic_byte;
		logic [7:0] end_byte;
		logic [7:0] expected_version;
	} cfg_t;

	typedef struct packed {
		logic       consumed;
		logic       frame_ended;
		logic       frame_good;
		logic       version_match;
		logic [7:0] command;
		logic [7:0] payload_length;
	} res_t;

endpackage

// File: hw/rtl/sfd_cfg.sv
module sfd_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [sfd_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [7:0]                     wr_data,
	output sfd_pkg::cfg_t                  cfg
);
	import sfd_pkg::*;

	cfg_t cfg_q;

	// register writes, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_byte        <= '0;
			cfg_q.magic_byte       <= '0;
			cfg_q.end_byte         <= '0;
			cfg_q.expected_version <= EXP_VER_RST;
		end else if (wr_en) begin
			case (wr_index)
				CFG_SYNC_BYTE:  cfg_q.sync_byte        <= wr_data;
				CFG_MAGIC_BYTE: cfg_q.magic_byte       <= wr_data;
				CFG_END_BYTE:   cfg_q.end_byte         <= wr_data;
				CFG_EXP_VER:    cfg_q.expected_version <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: hw/rtl/sfd_parser.sv
module sfd_parser #(
	parameter int FRAME_LIMIT = sfd_pkg::FRAME_LIMIT_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  logic [7:0]    rx_byte_s1,
	input  sfd_pkg::cfg_t cfg,
	output sfd_pkg::res_t res
);
	import sfd_pkg::*;

	localparam int CW = $clog2(FRAME_LIMIT + 1);
	localparam logic [CW-1:0] LIMIT_C  = CW'(FRAME_LIMIT);
	localparam logic [16:0]   LIMIT_W  = 17'(FRAME_LIMIT);

	// frame state
	logic          recv_q, recv_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] needed_q, needed_d;
	logic [7:0]    kind_q, kind_d;
	logic [7:0]    version_q, version_d;
	logic [7:0]    command_q, command_d;
	logic [15:0]   ann_q, ann_d;
	logic [7:0]    sum_q, sum_d;
	logic          sm_q, sm_d;
	logic          mok_q, mok_d;

	logic          start;
	logic [CW-1:0] pos;
	logic [CW-1:0] len;
	logic [CW-1:0] nd;
	logic [CW:0]   pos_w;
	logic [16:0]   full_len;
	logic          capped;

	always_comb begin
		recv_d    = recv_q;
		count_d   = count_q;
		needed_d  = needed_q;
		kind_d    = kind_q;
		version_d = version_q;
		command_d = command_q;
		ann_d     = ann_q;
		sum_d     = sum_q;
		sm_d      = sm_q;
		mok_d     = mok_q;
		res       = '0;
		start     = !recv_q && (rx_byte_s1 == cfg.sync_byte);
		pos       = start ? '0 : count_q;
		len       = pos + CW'(1);
		pos_w     = {1'b0, pos};
		nd        = start ? '0 : needed_q;
		full_len  = '0;
		capped    = 1'b0;

		if (recv_q || start) begin
			if (start) begin
				sum_d = '0;
				sm_d  = 1'b0;
				mok_d = 1'b0;
			end

			// header fields by position
			case (pos)
				CW'(1): mok_d     = (rx_byte_s1 == cfg.magic_byte);
				CW'(2): kind_d    = rx_byte_s1;
				CW'(3): version_d = rx_byte_s1;
				CW'(4): command_d = rx_byte_s1;
				CW'(5): ann_d     = {ann_q[15:8], rx_byte_s1};
				CW'(6): ann_d     = {rx_byte_s1, ann_q[7:0]};
				default: ;
			endcase

			// running checksum from the version byte through the payload, then compare at checksum byte
			if (pos >= CW'(3) && (nd == '0 || (pos_w + (CW+1)'(3)) <= {1'b0, nd}))
				sum_d = sum_d + rx_byte_s1;
			if (nd != '0 && (pos_w + (CW+1)'(2)) == {1'b0, nd})
				sm_d = (sum_d == rx_byte_s1);

			res.consumed = 1'b1;
			count_d      = len;
			recv_d       = 1'b1;
			needed_d     = nd;

			if (len >= CW'(4) && nd == '0 && !mok_d) begin
				// bad magic drops the frame
				recv_d       = 1'b0;
				count_d      = '0;
				needed_d     = '0;
				res.consumed = (rx_byte_s1 == cfg.sync_byte);
			end else begin
				// learn the length once the type fields are in
				if (len >= CW'(4) && nd == '0) begin
					if (kind_d == KIND_T && len >= CW'(7))
						full_len = 17'd9 + {1'b0, ann_d};
					else if (kind_d == KIND_D && len >= CW'(6))
						full_len = 17'd8 + {9'd0, ann_d[7:0]};
					if (full_len > LIMIT_W)
						needed_d = LIMIT_C;
					else
						needed_d = full_len[CW-1:0];
				end

				capped = (17'd9 + {1'b0, ann_d}) > LIMIT_W;

				// frame end, size limit
				if (needed_d != '0 && len >= needed_d) begin
					res.frame_ended = 1'b1;
					if (kind_d == KIND_T && !capped && sm_d
						&& rx_byte_s1 == cfg.end_byte) begin
						res.frame_good     = 1'b1;
						res.version_match  = (version_d == cfg.expected_version);
						res.command        = command_d;
						res.payload_length = ann_d[7:0];
					end
					recv_d   = 1'b0;
					count_d  = '0;
					needed_d = '0;
				end else if (len >= LIMIT_C) begin
					recv_d   = 1'b0;
					count_d  = '0;
					needed_d = '0;
				end
			end
		end
	end

	// state update per processed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recv_q    <= 1'b0;
			count_q   <= '0;
			needed_q  <= '0;
			kind_q    <= '0;
			version_q <= '0;
			command_q <= '0;
			ann_q     <= '0;
			sum_q     <= '0;
			sm_q      <= 1'b0;
			mok_q     <= 1'b0;
		end else if (step) begin
			recv_q    <= recv_d;
			count_q   <= count_d;
			needed_q  <= needed_d;
			kind_q    <= kind_d;
			version_q <= version_d;
			command_q <= command_d;
			ann_q     <= ann_d;
			sum_q     <= sum_d;
			sm_q      <= sm_d;
			mok_q     <= mok_d;
		end
	end

endmodule

// File: hw/rtl/serial_frame_deframer_core.sv
// Serial frame deframer. Takes one received byte per transaction and returns
// one result per byte, in order: whether the byte was consumed, and on the
// last byte of a frame whether it ended, whether a T frame passed its
// checksum and end byte checks, the version match, command and low byte of
// the payload length. Sustains one byte per clock unless the receiver stalls;
// a byte passes the input register, then the frame logic into the result
// register, which lets a new byte enter while an earlier result waits.
// FRAME_LIMIT bounds the frame size and the byte counter width. Write the
// configuration registers only while no byte is in flight.
module serial_frame_deframer_core #(
	parameter int FRAME_LIMIT = sfd_pkg::FRAME_LIMIT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    rx_byte,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          consumed,
	output logic                          frame_ended,
	output logic                          frame_good,
	output logic                          version_match,
	output logic [7:0]                    command,
	output logic [7:0]                    payload_length,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [sfd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                    cfg_data
);
	import sfd_pkg::*;

	cfg_t       cfg;
	res_t       res;
	res_t       res_s2;
	logic       valid_s1;
	logic       valid_s2;
	logic [7:0] rx_byte_s1;
	logic       step;

	assign cfg_ready = 1'b1;

	// configuration registers
	sfd_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// stage handshake
	assign step     = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || step;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	// frame logic
	sfd_parser #(
		.FRAME_LIMIT (FRAME_LIMIT)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.rx_byte_s1 (rx_byte_s1),
		.cfg        (cfg),
		.res        (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (step) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s2 <= res;
		end
	end

	assign out_valid      = valid_s2;
	assign consumed       = res_s2.consumed;
	assign frame_ended    = res_s2.frame_ended;
	assign frame_good     = res_s2.frame_good;
	assign version_match  = res_s2.version_match;
	assign command        = res_s2.command;
	assign payload_length = res_s2.payload_length;

endmodule

// File: tb/serial_frame_deframer_core_test.sv
`timescale 1ns / 1ps

module serial_frame_deframer_core_test;
	import sfd_pkg::*;

	localparam int FRAME_SIZE     = FRAME_LIMIT_DEF;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int PHASE_BYTES    = 24;

	// tracks the deframer state and the per-byte results it should produce
	class deframe_tracker;
		cfg_t        regs;
		bit          receiving;
		int unsigned pos_count;
		int unsigned need_len;
		logic [7:0]  kind;
		logic [7:0]  ver;
		logic [7:0]  cmd;
		logic [15:0] ann_len;
		logic [7:0]  sum;
		bit          sum_ok;
		bit          magic_ok;
		res_t        results_due[$];
		int          bad_results;

		function new();
			regs = '{8'h00, 8'h00, 8'h00, EXP_VER_RST};
			receiving = 0;
			pos_count = 0;
			need_len = 0;
			kind = '0;
			ver = '0;
			cmd = '0;
			ann_len = '0;
			sum = '0;
			sum_ok = 0;
			magic_ok = 0;
			bad_results = 0;
		endfunction

		function void go_hunting();
			receiving = 0;
			pos_count = 0;
			need_len = 0;
		endfunction

		// result of one received byte, advancing the frame state
		function res_t deframe_byte(logic [7:0] b);
			res_t        r;
			int unsigned p;
			r = '0;
			if (!receiving) begin
				if (b != regs.sync_byte)
					return r;
				receiving = 1;
				pos_count = 0;
				need_len = 0;
				sum = '0;
				sum_ok = 0;
				magic_ok = 0;
			end
			p = pos_count;
			pos_count = p + 1;

			// header fields by position
			case (p)
				1: magic_ok = (b == regs.magic_byte);
				2: kind = b;
				3: ver = b;
				4: cmd = b;
				5: ann_len[7:0] = b;
				6: ann_len[15:8] = b;
				default: ;
			endcase

			// running checksum up to the end of the payload
			if (p >= 3 && (need_len == 0 || p + 3 <= need_len))
				sum = sum + b;
			if (need_len != 0 && p + 2 == need_len)
				sum_ok = (sum == b);

			// magic check and length learning
			if (p + 1 >= 4 && need_len == 0) begin
				if (!magic_ok) begin
					go_hunting();
					r.consumed = (b == regs.sync_byte);
					return r;
				end
				if (kind == KIND_T && p + 1 >= 7)
					need_len = 9 + ann_len;
				else if (kind == KIND_D && p + 1 >= 6)
					need_len = 8 + ann_len[7:0];
				if (need_len > FRAME_SIZE)
					need_len = FRAME_SIZE;
			end

			r.consumed = 1'b1;

			// frame end and its checks
			if (need_len != 0 && p + 1 >= need_len) begin
				r.frame_ended = 1'b1;
				if (kind == KIND_T && (9 + ann_len) <= FRAME_SIZE && sum_ok &&
				    b == regs.end_byte) begin
					r.frame_good = 1'b1;
					r.version_match = (ver == regs.expected_version);
					r.command = cmd;
					r.payload_length = ann_len[7:0];
				end
				go_hunting();
				return r;
			end

			if (p + 1 >= FRAME_SIZE)
				go_hunting();
			return r;
		endfunction

		function void note_byte(logic [7:0] b);
			results_due.push_back(deframe_byte(b));
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (results_due.size() == 0) begin
				bad_results++;
				if (bad_results <= 10)
					$display("%0t: result with no byte pending: %p", $realtime, got);
				return;
			end
			want = results_due.pop_front();
			if (got.consumed !== want.consumed || got.frame_ended !== want.frame_ended ||
			    got.frame_good !== want.frame_good ||
			    got.version_match !== want.version_match ||
			    got.command !== want.command || got.payload_length !== want.payload_length) begin
				bad_results++;
				if (bad_results <= 10)
					$display("%0t: result mismatch: expected %p actual %p",
						$realtime, want, got);
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [7:0]           rx_byte = 8'h00;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic                 consumed;
	logic                 frame_ended;
	logic                 frame_good;
	logic                 version_match;
	logic [7:0]           command;
	logic [7:0]           payload_length;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_SYNC_BYTE;
	logic [7:0]           cfg_data = 8'h00;

	deframe_tracker tracker;
	res_t           seen_result;
	int             send_gap_pct = 28;
	int             recv_stall_pct = 83;
	int             bytes_sent = 0;
	int             quiet_cycles = 0;

	serial_frame_deframer_core #(
		.FRAME_LIMIT(FRAME_SIZE)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.consumed      (consumed),
		.frame_ended   (frame_ended),
		.frame_good    (frame_good),
		.version_match (version_match),
		.command       (command),
		.payload_length(payload_length),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// receiver back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// note accepted bytes first, then check accepted results
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				tracker.note_byte(rx_byte);
			if (out_valid && out_ready) begin
				seen_result.consumed = consumed;
				seen_result.frame_ended = frame_ended;
				seen_result.frame_good = frame_good;
				seen_result.version_match = version_match;
				seen_result.command = command;
				seen_result.payload_length = payload_length;
				tracker.check_result(seen_result);
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $realtime, quiet_cycles);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	function automatic logic [7:0] nonzero_flip();
		logic [7:0] f;
		f = 8'($urandom_range(255, 1));
		return f;
	endfunction

	function automatic logic [7:0] any_byte();
		logic [7:0] b;
		b = 8'($urandom_range(255));
		return b;
	endfunction

	// one byte transaction with optional leading gap
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		bytes_sent++;
	endtask

	// frames never run past the size limit
	task automatic send_frame_bytes(input logic [7:0] fb[$]);
		for (int i = 0; i < fb.size() && i < FRAME_SIZE; i++)
			send_byte(fb[i]);
	endtask

	task automatic send_t_frame(input logic [7:0] ver, input logic [7:0] cmd,
			input logic [15:0] plen, input bit sum_good, input bit end_good);
		logic [7:0] fb[$];
		logic [7:0] csum;
		logic [7:0] pb;
		fb.push_back(tracker.regs.sync_byte);
		fb.push_back(tracker.regs.magic_byte);
		fb.push_back(KIND_T);
		fb.push_back(ver);
		fb.push_back(cmd);
		fb.push_back(plen[7:0]);
		fb.push_back(plen[15:8]);
		csum = ver + cmd + plen[7:0] + plen[15:8];
		for (int i = 0; i < plen && i < FRAME_SIZE; i++) begin
			pb = any_byte();
			csum = csum + pb;
			fb.push_back(pb);
		end
		fb.push_back(sum_good ? csum : csum ^ nonzero_flip());
		fb.push_back(end_good ? tracker.regs.end_byte : tracker.regs.end_byte ^ nonzero_flip());
		send_frame_bytes(fb);
	endtask

	task automatic send_d_frame(input logic [7:0] dlen);
		logic [7:0] fb[$];
		fb.push_back(tracker.regs.sync_byte);
		fb.push_back(tracker.regs.magic_byte);
		fb.push_back(KIND_D);
		fb.push_back(any_byte());
		fb.push_back(any_byte());
		fb.push_back(dlen);
		for (int i = 0; i < dlen + 2; i++)
			fb.push_back(any_byte());
		send_frame_bytes(fb);
	endtask

	// wrong magic, dropped on the fourth byte
	task automatic send_bad_magic(input logic [7:0] fourth);
		send_byte(tracker.regs.sync_byte);
		send_byte(tracker.regs.magic_byte ^ nonzero_flip());
		send_byte(any_byte());
		send_byte(fourth);
	endtask

	// unknown kind runs to the size limit and is dropped
	task automatic send_unknown_kind();
		logic [7:0] fb[$];
		logic [7:0] k;
		do
			k = any_byte();
		while (k == KIND_T || k == KIND_D);
		fb.push_back(tracker.regs.sync_byte);
		fb.push_back(tracker.regs.magic_byte);
		fb.push_back(k);
		while (fb.size() < FRAME_SIZE)
			fb.push_back(any_byte());
		send_frame_bytes(fb);
	endtask

	task automatic send_noise();
		logic [7:0] b;
		if ($urandom_range(7) == 0)
			b = any_byte();
		else
			do
				b = any_byte();
			while (b == tracker.regs.sync_byte);
		send_byte(b);
	endtask

	// hold off input until every pending result has been taken
	task automatic wait_results_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tracker.results_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// all four registers in back-to-back transactions
	task automatic write_regs(input cfg_t v);
		logic [CFG_IDX_W-1:0] idx[4];
		logic [7:0]           vals[4];
		idx[0] = CFG_SYNC_BYTE;
		idx[1] = CFG_MAGIC_BYTE;
		idx[2] = CFG_END_BYTE;
		idx[3] = CFG_EXP_VER;
		vals[0] = v.sync_byte;
		vals[1] = v.magic_byte;
		vals[2] = v.end_byte;
		vals[3] = v.expected_version;
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= vals[i];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
		end
		cfg_valid <= 1'b0;
		tracker.regs = v;
	endtask

	initial begin
		cfg_t       phase_cfg;
		int         start_count;
		int         roll;
		bit         paused;
		logic [7:0] ver;
		logic [7:0] fourth;
		logic [15:0] plen;

		tracker = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: ignored extremes, sync inside a good frame, bad magic, empty D frame
		write_regs('{8'h7E, 8'hA5, 8'h03, 8'h02});
		send_byte(8'h00);
		send_byte(8'hFF);
		send_t_frame(8'h02, 8'h7E, 16'd0, 1'b1, 1'b1);
		send_bad_magic(8'h7E);
		send_d_frame(8'd0);
		wait_results_drained();

		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_gap_pct = 28;
					recv_stall_pct = 83;
					phase_cfg = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
				end
				1: begin
					send_gap_pct = 83;
					recv_stall_pct = 28;
					phase_cfg.sync_byte = any_byte();
					phase_cfg.magic_byte = any_byte();
					phase_cfg.end_byte = any_byte();
					phase_cfg.expected_version = any_byte();
				end
				default: begin
					send_gap_pct = 0;
					recv_stall_pct = 0;
					phase_cfg = '{8'h00, 8'h00, 8'h00, 8'h00};
				end
			endcase
			write_regs(phase_cfg);

			// one long frame in the first two phases: capped length, unknown kind
			case (ph)
				0: send_t_frame(any_byte(), any_byte(), 16'd248, 1'b1, 1'b1);
				1: send_unknown_kind();
				default: ;
			endcase

			start_count = bytes_sent;
			paused = 0;
			while (bytes_sent - start_count < PHASE_BYTES) begin
				if (ph == 1 && !paused && bytes_sent - start_count >= PHASE_BYTES / 2) begin
					wait_results_drained();
					paused = 1;
				end
				roll = $urandom_range(99);
				if (roll < 45) begin
					if ($urandom_range(9) == 0)
						plen = 16'($urandom_range(64, 17));
					else
						plen = 16'($urandom_range(16));
					ver = ($urandom_range(1) == 0) ? tracker.regs.expected_version : any_byte();
					send_t_frame(ver, any_byte(), plen, $urandom_range(99) < 85,
						$urandom_range(99) < 85);
				end else if (roll < 70) begin
					send_d_frame(8'($urandom_range(20)));
				end else if (roll < 80) begin
					fourth = ($urandom_range(3) == 0) ? tracker.regs.sync_byte : any_byte();
					send_bad_magic(fourth);
				end else begin
					repeat ($urandom_range(3, 1)) send_noise();
				end
			end
			wait_results_drained();
		end

		repeat (8) @(posedge clk);
		if (tracker.bad_results == 0 && tracker.results_due.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
